[hdl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants for the bounded deque with shift
// Transaction payloads, operation and status codes, controller states and
// the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

   // field widths
   localparam int COORD_W = 16;
   localparam int KIND_W  = 3;
   localparam int OCC_W   = 7;
   localparam int STAT_W  = 2;

   // operation kinds
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SHIFT      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd5;

   // result status codes
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [COORD_W-1:0] push_x;
      logic signed [COORD_W-1:0] push_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] popped_x;
      logic signed [COORD_W-1:0] popped_y;
      logic [OCC_W-1:0]          occupancy;
      logic [STAT_W-1:0]         status;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic exec;    // complete an operation that needs no read, load result
      logic issue;   // start a memory read and hold the operation
      logic finish;  // complete the held operation, load result
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_read;  // presented operation reads an entry
   } dp_stat_type;

endpackage

[hdl/bounded_deque_with_shift_top.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_shift_top: bounded double-ended queue of (x, y) pairs
// Ring buffer deque with push/pop at both ends, shift toward back and clear.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------
//   req     | in        | req_valid/req_stall  | req_data (kind, push_x/y)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_data (popped, occ, status)
//
// Pushes, clear and operations that read nothing complete from the idle state;
// pops of a non-empty queue and shift with two or more entries pass through the
// read state, for the registered read port of the entry memory.
// The result register lets a new transaction enter in the cycle its
// predecessor's result is taken.
// Reset clears state, front index, count and result valid; the entry memory
// is not cleared and needs no clearing pass.
// A stalled result holds; requests stall while a result is stalled.
// ----------------------------------------------------------------------------
module bounded_deque_with_shift_top #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bdq_pkg::rsp_type rsp_data
);

   bdq_pkg::dp_cmd_type  cmd;
   bdq_pkg::dp_stat_type stat;

   // sequencing
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   // storage and arithmetic
   bdq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_i  (req_data),
      .cmd_i  (cmd),
      .stat_o (stat),
      .rsp_o  (rsp_data)
   );

endmodule

[hdl/bdq_datapath.sv]
// ----------------------------------------------------------------------------
// bdq_datapath: ring buffer storage, pointers and result register
// Holds the entry memory, front index, entry count and the output register.
// Executes the commands issued by the controller.
// ----------------------------------------------------------------------------
module bdq_datapath #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bdq_pkg::req_type     req_i,
   input  bdq_pkg::dp_cmd_type  cmd_i,
   output bdq_pkg::dp_stat_type stat_o,
   output bdq_pkg::rsp_type     rsp_o
);

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = IW + 1;
   localparam int DW = 2 * bdq_pkg::COORD_W;
   localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
   localparam logic [SW-1:0] DEPTH_S   = SW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);

   logic [DW-1:0]             mem [QUEUE_DEPTH];
   logic [IW-1:0]             front_ff, front_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [DW-1:0]             rd_data_ff;
   logic [bdq_pkg::KIND_W-1:0] kind_ff;
   bdq_pkg::rsp_type          rsp_ff, rsp_in;
   logic                      rsp_load;

   logic                      wr_en;
   logic [IW-1:0]             wr_addr;
   logic [DW-1:0]             wr_data;
   logic [IW-1:0]             rd_addr;

   logic [IW-1:0]             front_prev, front_next, back_slot, last_slot;
   logic [SW-1:0]             back_sum, last_sum;
   logic                      full, empty, two_plus;
   logic                      is_pop;

   // ring arithmetic around the front index
   always_comb begin
      front_prev = (front_ff == '0) ? LAST_SLOT : front_ff - IW'(1);
      front_next = (front_ff == LAST_SLOT) ? '0 : front_ff + IW'(1);
      back_sum   = {1'b0, front_ff} + SW'(count_ff);
      last_sum   = back_sum - SW'(1);
      back_slot  = (back_sum >= DEPTH_S) ? IW'(back_sum - DEPTH_S) : IW'(back_sum);
      last_slot  = (last_sum >= DEPTH_S) ? IW'(last_sum - DEPTH_S) : IW'(last_sum);
      full       = (count_ff == DEPTH_C);
      empty      = (count_ff == '0);
      two_plus   = (count_ff >= CW'(2));
   end

   // read decision and read address for the presented operation
   always_comb begin
      is_pop = (req_i.kind == bdq_pkg::KIND_POP_FRONT) ||
               (req_i.kind == bdq_pkg::KIND_POP_BACK);
      stat_o.needs_read = (is_pop && !empty) ||
                          ((req_i.kind == bdq_pkg::KIND_SHIFT) && two_plus);
      rd_addr = (req_i.kind == bdq_pkg::KIND_POP_BACK) ? last_slot : front_ff;
   end

   // next pointer, count, write port and result
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = front_prev;
      wr_data  = {req_i.push_x, req_i.push_y};
      rsp_load = 1'b0;
      rsp_in   = rsp_ff;
      rsp_in.popped_x = '0;
      rsp_in.popped_y = '0;
      rsp_in.status   = bdq_pkg::STATUS_OK;

      if (cmd_i.exec) begin
         rsp_load = 1'b1;
         case (req_i.kind)
            bdq_pkg::KIND_PUSH_FRONT: begin
               if (full) begin
                  rsp_in.status = bdq_pkg::STATUS_FULL;
               end else begin
                  front_in = front_prev;
                  count_in = count_ff + CW'(1);
                  wr_en    = 1'b1;
                  wr_addr  = front_prev;
               end
            end
            bdq_pkg::KIND_PUSH_BACK: begin
               if (full) begin
                  rsp_in.status = bdq_pkg::STATUS_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
                  wr_en    = 1'b1;
                  wr_addr  = back_slot;
               end
            end
            bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_POP_BACK: begin
               // only reached here when empty
               rsp_in.status = bdq_pkg::STATUS_EMPTY;
            end
            bdq_pkg::KIND_CLEAR: begin
               front_in = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end else if (cmd_i.finish) begin
         rsp_load = 1'b1;
         case (kind_ff)
            bdq_pkg::KIND_POP_FRONT: begin
               count_in = count_ff - CW'(1);
               front_in = (count_ff == CW'(1)) ? '0 : front_next;
               rsp_in.popped_x = rd_data_ff[DW-1:bdq_pkg::COORD_W];
               rsp_in.popped_y = rd_data_ff[bdq_pkg::COORD_W-1:0];
            end
            bdq_pkg::KIND_POP_BACK: begin
               count_in = count_ff - CW'(1);
               front_in = (count_ff == CW'(1)) ? '0 : front_ff;
               rsp_in.popped_x = rd_data_ff[DW-1:bdq_pkg::COORD_W];
               rsp_in.popped_y = rd_data_ff[bdq_pkg::COORD_W-1:0];
            end
            default: begin
               // shift: copy of the front goes into a new front slot
               front_in = front_prev;
               wr_en    = 1'b1;
               wr_addr  = front_prev;
               wr_data  = rd_data_ff;
            end
         endcase
      end
      rsp_in.occupancy = bdq_pkg::OCC_W'(count_in);
   end

   // entry memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd_i.issue) begin
         rd_data_ff <= mem[rd_addr];
         kind_ff    <= req_i.kind;
      end
   end

   // pointer and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_o = rsp_ff;

endmodule

[hdl/bdq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdq_ctrl: handshake and sequencing controller
// Accepts request transactions, sequences read operations through the read state
// and tracks the result register's valid flag.
// ----------------------------------------------------------------------------
module bdq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bdq_pkg::dp_stat_type stat_i,
   output bdq_pkg::dp_cmd_type  cmd_o
);

   bdq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               rsp_taken;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      rsp_taken    = rsp_valid_ff && !rsp_stall;
      req_stall    = (state_ff != bdq_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
      accept       = req_valid && !req_stall;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_taken;
      cmd_o        = '0;
      case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (accept) begin
               if (stat_i.needs_read) begin
                  cmd_o.issue = 1'b1;
                  state_in    = bdq_pkg::ST_READ;
               end else begin
                  cmd_o.exec   = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         bdq_pkg::ST_READ: begin
            cmd_o.finish = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = bdq_pkg::ST_IDLE;
         end
         default: begin
            state_in = bdq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // result register is free while a read completes
   a_read_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdq_pkg::ST_READ) |-> !rsp_valid_ff)
      else $error("result pending during read completion");

   // a read operation always moves into the read state
   a_issue_to_read: assert property (@(posedge clock) disable iff (reset)
      cmd_o.issue |=> (state_ff == bdq_pkg::ST_READ))
      else $error("read issued without read state");

   // read state returns to idle and produces a result
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bdq_pkg::ST_READ) |=> (rsp_valid_ff && state_ff == bdq_pkg::ST_IDLE))
      else $error("read completion did not produce a result");

   // commands are mutually exclusive
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd_o.exec, cmd_o.issue, cmd_o.finish}))
      else $error("overlapping datapath commands");

endmodule
